// File: sv/pdc_pkg.sv
// Shared types, constants and the control store of the deadband PID block.
// Used by pdc_divider and pid_deadband_controller; depends on nothing else.
`default_nettype none

package pdc_pkg;

    // Default fixed-point position of angles and gains
    localparam int FRAC_BITS_DEF = 8;

    // Configuration register indexes and reset values
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SETPOINT = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_DEADBAND = 3'd4,
        REG_PERIOD   = 3'd5
    } cfg_reg_idx_t;

    localparam logic signed [31:0] SETPOINT_RST = 32'sd0;
    localparam logic signed [23:0] GAIN_P_RST   = 24'sd8960;
    localparam logic signed [23:0] GAIN_I_RST   = 24'sd0;
    localparam logic signed [23:0] GAIN_D_RST   = 24'sd5120;
    localparam logic [7:0]         DEADBAND_RST = 8'd1;
    localparam logic [9:0]         PERIOD_RST   = 10'd5;

    // Shared divider: wide magnitude dividend, narrow divisor, 4 bits a cycle
    localparam int DIV_W      = 72;
    localparam int DVS_W      = 10;
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    // Integral gain scale (integral is kept in error times milliseconds)
    localparam logic [DVS_W-1:0] MILLI = 10'd1000;

    // Derivative term limit, 2^61
    localparam logic [DIV_W-1:0] DTERM_LIM = 72'd1 << 61;

    typedef struct packed {
        logic start;
        logic neg;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic neg;
    } div_status_t;

    // Control word fields
    typedef enum logic [1:0] {
        COND_NONE,
        COND_INPUT,
        COND_DIV,
        COND_OUTPUT
    } cond_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_ERROR,
        OP_INTEGRATE,
        OP_TERM_P,
        OP_TERM_I,
        OP_TERM_D,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ERR_PER,
        MUL_P_ERR,
        MUL_I_LO,
        MUL_I_HI,
        MUL_D_DIFF
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_HI,
        ACC_X1000_A,
        ACC_X1000_B
    } acc_op_t;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_BY_MILLI,
        DIV_BY_PERIOD
    } div_sel_t;

    localparam int NUM_STEPS = 13;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    localparam logic [STEP_W-1:0] STEP_ACCEPT = '0;

    typedef struct packed {
        cond_t             cond;
        logic              jump;
        logic [STEP_W-1:0] target;
        dp_op_t            op;
        mul_sel_t          mul;
        acc_op_t           acc;
        div_sel_t          div;
    } ctl_word_t;

    function automatic ctl_word_t mk_word(
        input cond_t    cond,
        input logic     jump,
        input dp_op_t   op,
        input mul_sel_t mul,
        input acc_op_t  acc,
        input div_sel_t div
    );
        ctl_word_t w;
        w.cond   = cond;
        w.jump   = jump;
        w.target = STEP_ACCEPT;
        w.op     = op;
        w.mul    = mul;
        w.acc    = acc;
        w.div    = div;
        return w;
    endfunction

    // Control store: one word per step. A word waits while its condition
    // holds, then does its work and falls through or jumps back to accept.
    function automatic ctl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctl_word_t w;
        unique case (step)
            4'd0:  w = mk_word(COND_INPUT,  1'b0, OP_ACCEPT,    MUL_NONE,    ACC_HOLD,
                               DIV_NONE);
            4'd1:  w = mk_word(COND_NONE,   1'b0, OP_ERROR,     MUL_NONE,    ACC_HOLD,
                               DIV_NONE);
            4'd2:  w = mk_word(COND_NONE,   1'b0, OP_NONE,      MUL_ERR_PER, ACC_HOLD,
                               DIV_NONE);
            4'd3:  w = mk_word(COND_NONE,   1'b0, OP_INTEGRATE, MUL_P_ERR,   ACC_HOLD,
                               DIV_NONE);
            4'd4:  w = mk_word(COND_NONE,   1'b0, OP_TERM_P,    MUL_I_LO,    ACC_HOLD,
                               DIV_NONE);
            4'd5:  w = mk_word(COND_NONE,   1'b0, OP_NONE,      MUL_I_HI,    ACC_LOAD,
                               DIV_NONE);
            4'd6:  w = mk_word(COND_NONE,   1'b0, OP_NONE,      MUL_NONE,    ACC_ADD_HI,
                               DIV_NONE);
            4'd7:  w = mk_word(COND_NONE,   1'b0, OP_NONE,      MUL_D_DIFF,  ACC_HOLD,
                               DIV_BY_MILLI);
            4'd8:  w = mk_word(COND_NONE,   1'b0, OP_NONE,      MUL_NONE,    ACC_X1000_A,
                               DIV_NONE);
            4'd9:  w = mk_word(COND_NONE,   1'b0, OP_NONE,      MUL_NONE,    ACC_X1000_B,
                               DIV_NONE);
            4'd10: w = mk_word(COND_DIV,    1'b0, OP_TERM_I,    MUL_NONE,    ACC_HOLD,
                               DIV_BY_PERIOD);
            4'd11: w = mk_word(COND_DIV,    1'b0, OP_TERM_D,    MUL_NONE,    ACC_HOLD,
                               DIV_NONE);
            4'd12: w = mk_word(COND_OUTPUT, 1'b1, OP_EMIT,      MUL_NONE,    ACC_HOLD,
                               DIV_NONE);
            default: w = mk_word(COND_NONE, 1'b1, OP_NONE,      MUL_NONE,    ACC_HOLD,
                               DIV_NONE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: sv/pdc_divider.sv
// Iterative unsigned divider, four quotient bits a cycle, with a sign tag.
// Depends on pdc_pkg for widths and the control and status structs.
`default_nettype none

module pdc_divider
    import pdc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire div_ctrl_t         ctrl,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [DVS_W-1:0]  divisor,
    output div_status_t            status,
    output logic [DIV_W-1:0]       quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     work_reg;
    logic [DIV_W-1:0]     work_next;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     rem_next;
    logic [DVS_W-1:0]     dvs_reg;
    logic                 neg_reg;

    // Restoring steps: dividend bits leave at the top, quotient bits enter below
    always_comb begin
        logic [DVS_W:0] trial;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial     = {rem_next, work_next[DIV_W-1]};
            work_next = {work_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next     = DVS_W'(trial - {1'b0, dvs_reg});
                work_next[0] = 1'b1;
            end else begin
                rem_next = trial[DVS_W-1:0];
            end
        end
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctrl.start) begin
            cnt_reg <= DIV_CNT_W'(DIV_CYCLES);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - {{(DIV_CNT_W-1){1'b0}}, 1'b1};
        end
    end

    // Load operands on start, then advance one group of bits a cycle
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            neg_reg  <= ctrl.neg;
        end else if (cnt_reg != '0) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign status.busy = (cnt_reg != '0);
    assign status.neg  = neg_reg;
    assign quotient    = work_reg;

`ifndef SYNTHESIS
    // No restart while a division runs
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> cnt_reg == '0)
        else $error("divider started while busy");

    // A started division runs its full count on a nonzero divisor
    a_start_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |=> (cnt_reg == DIV_CNT_W'(DIV_CYCLES) && dvs_reg != '0))
        else $error("divider start did not load a valid divisor");

    // Partial remainder stays below the divisor
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 |-> rem_reg < dvs_reg)
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

// File: sv/pid_deadband_controller.sv
// PID controller with error deadband: top level, sequencer and datapath.
// Depends on pdc_pkg (control store, types) and pdc_divider.
//
// Use: one measured angle per control tick on the s_ stream (s_tdata holds
// measured_angle, s_tuser the start_run flag that clears the integral and
// the previous error before the step). Each item gives one result on the
// m_ stream: m_tdata holds the saturated drive, m_tuser the clip flag.
// Gains, setpoint, deadband and period are written on the cfg_ channel,
// which is always ready; write them only while no item is in flight.
// A small control store steps a shared 32x32 multiplier, a 72-bit
// accumulator and one divider that yields four quotient bits a cycle.
// The result is registered at the final step; a new item is taken only
// after the last one has passed that step. Most of that time goes to the
// two divisions (integral term by 1000, derivative term by the period).
// s_tready is high only at the accept step. The result waits in the
// output register while the receiver stalls; the next item is then fully
// processed and held at the final step until the register frees.
// Reset (aresetn low, synchronous) clears integral and previous error,
// loads the register defaults and drops m_tvalid.
`default_nettype none

module pid_deadband_controller
    import pdc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // [31:0] measured_angle
    input  wire logic [0:0]            s_tuser,   // [0] start_run
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] drive
    output logic [0:0]                 m_tuser,   // [0] clipped
    // Configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SHIFT = 2 * FRAC_BITS;
    localparam logic [63:0] ROUND_BIAS = (64'd1 << SHIFT) - 64'd1;

    // Sequencer
    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    ctl_word_t         ctl;
    logic              stall;
    logic              step_en;

    // Configuration
    logic signed [31:0] setpoint_reg;
    logic signed [23:0] gain_p_reg;
    logic signed [23:0] gain_i_reg;
    logic signed [23:0] gain_d_reg;
    logic [7:0]         deadband_reg;
    logic [9:0]         period_reg;

    // Controller state
    logic signed [47:0] integ_reg;
    logic signed [47:0] integ_next;
    logic signed [31:0] prev_err_reg;

    // Datapath
    logic signed [31:0] angle_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] err_next;
    logic [63:0]        prod_reg;
    logic [63:0]        prod_next;
    logic               prod_neg_reg;
    logic               prod_neg_next;
    logic [DIV_W-1:0]   acc_reg;
    logic [DIV_W-1:0]   acc_next;
    logic signed [63:0] total_reg;
    logic signed [63:0] total_next;

    // Output register
    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg;
    logic               m_tuser_reg;
    logic [7:0]         drive_next;
    logic               clip_next;

    // Divider
    div_ctrl_t          div_ctl;
    div_status_t        div_st;
    logic [DIV_W-1:0]   div_quo;
    logic [DVS_W-1:0]   div_dvs;

    // Operand magnitudes and signs
    logic [9:0]         per_eff;
    logic [31:0]        err_mag;
    logic [23:0]        gp_mag;
    logic [23:0]        gi_mag;
    logic [23:0]        gd_mag;
    logic [47:0]        integ_mag;
    logic [32:0]        diff_full;
    logic [31:0]        diff_mag;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic signed [63:0] prod_sv;
    logic [DIV_W-1:0]   prod_w;

    // Sequencer: fetch, stall on the word's condition, advance or jump
    assign ctl = ucode_rom(pc_reg);

    always_comb begin
        unique case (ctl.cond)
            COND_NONE:   stall = 1'b0;
            COND_INPUT:  stall = !s_tvalid;
            COND_DIV:    stall = div_st.busy;
            COND_OUTPUT: stall = m_tvalid_reg && !m_tready;
            default:     stall = 1'b0;
        endcase
    end

    assign step_en = !stall;

    always_comb begin
        if (stall) begin
            pc_next = pc_reg;
        end else if (ctl.jump) begin
            pc_next = ctl.target;
        end else begin
            pc_next = pc_reg + {{(STEP_W-1){1'b0}}, 1'b1};
        end
    end

    assign s_tready  = (ctl.op == OP_ACCEPT);
    assign cfg_ready = 1'b1;

    // Magnitudes of signed operands; a zero period counts as one
    assign per_eff   = (period_reg == '0) ? 10'd1 : period_reg;
    assign err_mag   = err_reg[31] ? (32'd0 - err_reg) : err_reg;
    assign gp_mag    = gain_p_reg[23] ? (24'd0 - gain_p_reg) : gain_p_reg;
    assign gi_mag    = gain_i_reg[23] ? (24'd0 - gain_i_reg) : gain_i_reg;
    assign gd_mag    = gain_d_reg[23] ? (24'd0 - gain_d_reg) : gain_d_reg;
    assign integ_mag = integ_reg[47] ? (48'd0 - integ_reg) : integ_reg;
    assign diff_full = {err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg};
    assign diff_mag  = diff_full[32] ? 32'(33'd0 - diff_full) : diff_full[31:0];

    // Error: saturate to 32 bits, then zero inside the deadband
    always_comb begin
        logic [32:0] raw;
        logic [31:0] sat;
        logic [31:0] sat_mag;
        logic [31:0] thr;
        raw = {setpoint_reg[31], setpoint_reg} - {angle_reg[31], angle_reg};
        if (raw[32] != raw[31]) begin
            sat = raw[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sat = raw[31:0];
        end
        sat_mag = sat[31] ? (32'd0 - sat) : sat;
        thr     = {24'd0, deadband_reg} << FRAC_BITS;
        err_next = (sat_mag < thr) ? 32'sd0 : $signed(sat);
    end

    // Shared multiplier operand selection
    always_comb begin
        unique case (ctl.mul)
            MUL_ERR_PER: begin
                mul_a = err_mag;
                mul_b = {22'd0, per_eff};
                prod_neg_next = err_reg[31];
            end
            MUL_P_ERR: begin
                mul_a = err_mag;
                mul_b = {8'd0, gp_mag};
                prod_neg_next = err_reg[31] ^ gain_p_reg[23];
            end
            MUL_I_LO: begin
                mul_a = {8'd0, integ_mag[23:0]};
                mul_b = {8'd0, gi_mag};
                prod_neg_next = integ_reg[47] ^ gain_i_reg[23];
            end
            MUL_I_HI: begin
                mul_a = {8'd0, integ_mag[47:24]};
                mul_b = {8'd0, gi_mag};
                prod_neg_next = integ_reg[47] ^ gain_i_reg[23];
            end
            MUL_D_DIFF: begin
                mul_a = diff_mag;
                mul_b = {8'd0, gd_mag};
                prod_neg_next = diff_full[32] ^ gain_d_reg[23];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
                prod_neg_next = prod_neg_reg;
            end
        endcase
    end

    assign prod_next = {32'd0, mul_a} * {32'd0, mul_b};
    assign prod_sv   = $signed(prod_neg_reg ? (64'd0 - prod_reg) : prod_reg);
    assign prod_w    = {{(DIV_W-64){1'b0}}, prod_reg};

    // Accumulator: build wide products; x1000 as x1024 - x16 - x8
    always_comb begin
        unique case (ctl.acc)
            ACC_HOLD:    acc_next = acc_reg;
            ACC_LOAD:    acc_next = prod_w;
            ACC_ADD_HI:  acc_next = acc_reg + (prod_w << 24);
            ACC_X1000_A: acc_next = (prod_w << 10) - (prod_w << 4);
            ACC_X1000_B: acc_next = acc_reg - (prod_w << 3);
            default:     acc_next = acc_reg;
        endcase
    end

    // Integral update, saturated to 48 bits
    always_comb begin
        logic signed [49:0] sum;
        sum = $signed({{2{integ_reg[47]}}, integ_reg}) + $signed(prod_sv[49:0]);
        if (!sum[49] && sum[48:47] != 2'b00) begin
            integ_next = {1'b0, {47{1'b1}}};
        end else if (sum[49] && sum[48:47] != 2'b11) begin
            integ_next = {1'b1, {47{1'b0}}};
        end else begin
            integ_next = sum[47:0];
        end
    end

    // Term accumulation
    always_comb begin
        logic [63:0] mag;
        total_next = total_reg;
        mag        = '0;
        unique case (ctl.op)
            OP_TERM_P: begin
                total_next = prod_sv;
            end
            OP_TERM_I: begin
                mag = div_quo[63:0];
                total_next = total_reg + $signed(div_st.neg ? (64'd0 - mag) : mag);
            end
            OP_TERM_D: begin
                mag = (div_quo > DTERM_LIM) ? DTERM_LIM[63:0] : div_quo[63:0];
                total_next = total_reg + $signed(div_st.neg ? (64'd0 - mag) : mag);
            end
            default: begin
                total_next = total_reg;
            end
        endcase
    end

    // Drive: truncate toward zero to whole steps, saturate to a byte
    always_comb begin
        logic signed [63:0] biased;
        logic signed [63:0] scaled;
        biased = total_reg + $signed(total_reg[63] ? ROUND_BIAS : 64'd0);
        scaled = biased >>> SHIFT;
        if (scaled > 64'sd127) begin
            drive_next = 8'h7F;
            clip_next  = 1'b1;
        end else if (scaled < -64'sd128) begin
            drive_next = 8'h80;
            clip_next  = 1'b1;
        end else begin
            drive_next = scaled[7:0];
            clip_next  = 1'b0;
        end
    end

    // Divider start and operand choice
    assign div_ctl.start = step_en && (ctl.div != DIV_NONE);
    assign div_ctl.neg   = prod_neg_reg;
    assign div_dvs       = (ctl.div == DIV_BY_PERIOD) ? per_eff : MILLI;

    pdc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctl),
        .dividend (acc_reg),
        .divisor  (div_dvs),
        .status   (div_st),
        .quotient (div_quo)
    );

    // Control state, configuration, controller state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= STEP_ACCEPT;
            m_tvalid_reg <= 1'b0;
            setpoint_reg <= SETPOINT_RST;
            gain_p_reg   <= GAIN_P_RST;
            gain_i_reg   <= GAIN_I_RST;
            gain_d_reg   <= GAIN_D_RST;
            deadband_reg <= DEADBAND_RST;
            period_reg   <= PERIOD_RST;
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end else begin
            pc_reg <= pc_next;

            if (cfg_valid) begin
                unique case (cfg_reg_idx_t'(cfg_index))
                    REG_SETPOINT: setpoint_reg <= $signed(cfg_data[31:0]);
                    REG_GAIN_P:   gain_p_reg   <= $signed(cfg_data[23:0]);
                    REG_GAIN_I:   gain_i_reg   <= $signed(cfg_data[23:0]);
                    REG_GAIN_D:   gain_d_reg   <= $signed(cfg_data[23:0]);
                    REG_DEADBAND: deadband_reg <= cfg_data[7:0];
                    REG_PERIOD:   period_reg   <= cfg_data[9:0];
                    default: ;
                endcase
            end

            // Start flag clears history on the transfer itself
            if (step_en && ctl.op == OP_ACCEPT && s_tuser[0]) begin
                integ_reg    <= '0;
                prev_err_reg <= '0;
            end else if (step_en && ctl.op == OP_INTEGRATE) begin
                integ_reg <= integ_next;
            end else if (step_en && ctl.op == OP_EMIT) begin
                prev_err_reg <= err_reg;
            end

            if (step_en && ctl.op == OP_EMIT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (step_en && ctl.op == OP_ACCEPT) begin
            angle_reg <= $signed(s_tdata[31:0]);
        end
        if (step_en && ctl.op == OP_ERROR) begin
            err_reg <= err_next;
        end
        if (step_en && ctl.mul != MUL_NONE) begin
            prod_reg     <= prod_next;
            prod_neg_reg <= prod_neg_next;
        end
        if (step_en) begin
            acc_reg   <= acc_next;
            total_reg <= total_next;
        end
        if (step_en && ctl.op == OP_EMIT) begin
            m_tdata_reg <= drive_next;
            m_tuser_reg <= clip_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef SYNTHESIS
    // A clipped result always sits at one of the byte limits
    a_clip_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'h7F || m_tdata == 8'h80))
        else $error("clip flag set on an unsaturated drive");

    // The program leaves no division running when it returns to accept
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == STEP_ACCEPT) |-> !div_st.busy)
        else $error("divider busy at accept step");

    // A start flag clears the integral and the previous error
    a_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0]) |=> (integ_reg == '0 && prev_err_reg == '0))
        else $error("start flag did not clear controller history");
`endif

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for pid_deadband_controller: streams angle samples, rewrites
// the loop settings between phases and checks each drive word against a local PID
// model or a typed table entry. Depends on pdc_pkg and the controller RTL.

module tb_top;
    import pdc_pkg::*;

    localparam int CLK_HIGH     = 6;
    localparam int CLK_LOW      = 6;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 600;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 60;
    localparam int RUN_LIMIT_NS = 7_200_000;
    localparam int NUM_ROWS     = 13;

    // Indexes outside the register map; writes to them must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam longint INTEG_MAX   = (longint'(1) <<< 47) - 1;
    localparam longint INTEG_MIN   = -(longint'(1) <<< 47);
    localparam longint DTERM_CAP   = longint'(1) <<< 61;
    localparam longint MILLI_SCALE = 1000;
    localparam longint ERR_MAX     = 64'sd2147483647;
    localparam longint ERR_MIN     = -64'sd2147483648;

    typedef enum int {
        PH_TYPICAL,
        PH_MAX,
        PH_MIN,
        PH_WILD,
        PH_WINDUP
    } phase_kind_t;

    typedef struct packed {
        logic signed [7:0] drive;
        logic              clipped;
    } drive_word_t;

    typedef struct {
        logic [31:0] angle;
        logic        start;
        logic        typed;
        drive_word_t want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;    // [31:0] measured_angle
    logic [0:0]            s_tuser = '0;    // [0] start_run
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;         // [7:0] drive
    logic [0:0]            m_tuser;         // [0] clipped
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the loop settings and the controller state
    logic signed [31:0] sh_setpoint = SETPOINT_RST;
    logic signed [23:0] sh_gain_p   = GAIN_P_RST;
    logic signed [23:0] sh_gain_i   = GAIN_I_RST;
    logic signed [23:0] sh_gain_d   = GAIN_D_RST;
    logic [7:0]         sh_deadband = DEADBAND_RST;
    logic [9:0]         sh_period   = PERIOD_RST;
    longint             integ_acc   = 0;
    longint             last_err    = 0;

    drive_word_t pending_drives[$];
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          hold_request   = 0;
    logic        idle_on        = 1'b1;

    // Reset values, angle extremes and deadband edges, then derivative swings
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{32'h0000_0000, 1'b1, 1'b1, '{8'sd0,    1'b0}},
        '{32'h8000_0000, 1'b1, 1'b1, '{8'sd127,  1'b1}},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, '{-8'sd128, 1'b1}},
        '{32'h0000_00FF, 1'b1, 1'b1, '{8'sd0,    1'b0}},
        '{32'hFFFF_FF01, 1'b1, 1'b1, '{8'sd0,    1'b0}},
        '{32'h0000_0100, 1'b0, 1'b0, '0},
        '{32'hFFFF_FF00, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h0000_0100, 1'b1, 1'b0, '0}
    };

    pid_deadband_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #CLK_LOW aclk = 1'b1;
        #CLK_HIGH aclk = 1'b0;
    end

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the shadow PID state by one angle sample and return the drive word
    function automatic drive_word_t compute_drive(input logic [31:0] angle, input logic start);
        longint      setp, kp, ki, kd, band, per, err, diff, prod, quo, rem;
        longint      p_term, i_term, d_term, total, drv;
        drive_word_t res;
        setp = longint'(sh_setpoint);
        kp   = longint'(sh_gain_p);
        ki   = longint'(sh_gain_i);
        kd   = longint'(sh_gain_d);
        band = longint'(sh_deadband);
        per  = longint'(sh_period);
        if (start) begin
            integ_acc = 0;
            last_err  = 0;
        end
        if (per == 0) per = 1;

        // Error, saturated to 32 bits, then forced to zero inside the deadband
        err  = sat(setp - longint'($signed(angle)), ERR_MIN, ERR_MAX);
        band = band <<< FRAC_BITS_DEF;
        if (err < band && err > -band) err = 0;

        integ_acc = sat(integ_acc + err * per, INTEG_MIN, INTEG_MAX);
        p_term = kp * err;

        // Integral term split into quotient and remainder so it stays exact
        quo    = integ_acc / MILLI_SCALE;
        rem    = integ_acc % MILLI_SCALE;
        i_term = ki * quo + (ki * rem) / MILLI_SCALE;

        // Derivative term scaled by 1000/period, capped at 2^61
        diff = err - last_err;
        prod = kd * diff;
        quo  = prod / per;
        rem  = prod % per;
        if (quo > DTERM_CAP / MILLI_SCALE)
            d_term = DTERM_CAP;
        else if (quo < -(DTERM_CAP / MILLI_SCALE))
            d_term = -DTERM_CAP;
        else
            d_term = sat(quo * MILLI_SCALE + (rem * MILLI_SCALE) / per, -DTERM_CAP, DTERM_CAP);
        last_err = err;

        total       = p_term + i_term + d_term;
        drv         = total / (longint'(1) <<< (2 * FRAC_BITS_DEF));
        res.clipped = (drv > 127) || (drv < -128);
        res.drive   = 8'(sat(drv, -128, 127));
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 15);
        return $urandom_range(16, 60);
    endfunction

    // One register transfer; bits above the register width carry junk
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val,
                             input int width);
        logic [31:0] keep;
        logic [31:0] word;
        keep = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        word = (val & keep) | ($urandom() & ~keep);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SETPOINT: sh_setpoint = word;
            REG_GAIN_P:   sh_gain_p   = word[23:0];
            REG_GAIN_I:   sh_gain_i   = word[23:0];
            REG_GAIN_D:   sh_gain_d   = word[23:0];
            REG_DEADBAND: sh_deadband = word[7:0];
            REG_PERIOD:   sh_period   = word[9:0];
            default: ;
        endcase
    endtask

    // Write every register for the coming phase
    task automatic load_phase(input phase_kind_t kind);
        logic [31:0] sp;
        logic [23:0] kp, ki, kd;
        logic [7:0]  db;
        logic [9:0]  per;
        logic [31:0] r;
        case (kind)
            PH_MAX: begin
                sp = 32'h7FFF_FFFF; kp = 24'h7F_FFFF; ki = 24'h7F_FFFF; kd = 24'h7F_FFFF;
                db = 8'hFF; per = 10'd1023;
            end
            PH_MIN: begin
                sp = 32'h8000_0000; kp = 24'h80_0000; ki = 24'h80_0000; kd = 24'h80_0000;
                db = 8'h00; per = 10'd0;
            end
            PH_WILD: begin
                sp = $urandom(); kp = 24'($urandom()); ki = 24'($urandom());
                kd = 24'($urandom()); db = 8'($urandom()); per = 10'($urandom());
            end
            PH_WINDUP: begin
                sp = 32'h0; kp = 24'($urandom_range(0, 512)); ki = 24'($urandom_range(1, 16));
                kd = 24'h0; db = 8'h00; per = 10'd1023;
            end
            default: begin
                r  = $urandom();
                sp = {{12{r[19]}}, r[19:0]};
                kp = 24'($urandom_range(0, 1024));
                ki = 24'($urandom_range(0, 64));
                kd = 24'($urandom_range(0, 1024));
                if ($urandom_range(0, 1)) kp = -kp;
                if ($urandom_range(0, 1)) ki = -ki;
                if ($urandom_range(0, 1)) kd = -kd;
                db  = 8'($urandom_range(0, 4));
                per = ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(1, 20));
            end
        endcase
        write_reg(REG_SETPOINT, sp, 32);
        write_reg(REG_GAIN_P, {8'h0, kp}, 24);
        write_reg(REG_GAIN_I, {8'h0, ki}, 24);
        write_reg(REG_GAIN_D, {8'h0, kd}, 24);
        write_reg(REG_DEADBAND, {24'h0, db}, 8);
        write_reg(REG_PERIOD, {22'h0, per}, 10);
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom(), 32);
        cfg_valid <= 1'b0;
    endtask

    // Angle sample for the current phase: near the setpoint, deadband edges,
    // extremes or anything at all; in windup, far negative then far positive
    function automatic logic [31:0] pick_angle(input phase_kind_t kind, input int n);
        int          r, span;
        logic [31:0] off, band_w;
        if (kind == PH_WINDUP)
            return (n < 70) ? (32'h8000_0000 | ($urandom() & 32'h00FF_FFFF))
                            : (32'h7F00_0000 | ($urandom() & 32'h00FF_FFFF));
        r      = $urandom_range(0, 99);
        band_w = 32'(sh_deadband) << FRAC_BITS_DEF;
        if (r < 60) begin
            span = 4 * $urandom_range(2, 5);
            off  = $urandom() & ((32'd1 << span) - 32'd1);
            if ($urandom_range(0, 1)) off = -off;
            return sh_setpoint + off;
        end
        if (r < 75) return $urandom();
        if (r < 90) begin
            case ($urandom_range(0, 3))
                0: return sh_setpoint + band_w;
                1: return sh_setpoint - band_w;
                2: return sh_setpoint + band_w - 32'd1;
                default: return sh_setpoint - band_w + 32'd1;
            endcase
        end
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Offer one sample, record its drive word on transfer, then maybe idle
    task automatic send_item(input logic [31:0] angle, input logic start, input logic typed,
                             input drive_word_t want);
        drive_word_t predicted;
        int          gap;
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        predicted = compute_drive(angle, start);
        pending_drives.push_back(typed ? want : predicted);
        gap = (idle_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            s_tuser  <= 1'($urandom());
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and hold until every outstanding drive word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_drives.size() != 0);
    endtask

    // Stimulus
    initial begin
        int          phase, n, len, random_sent;
        phase_kind_t kind;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_item(directed_rows[i].angle, directed_rows[i].start,
                      directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase)
                0: kind = PH_MAX;
                1: kind = PH_MIN;
                2: kind = PH_WINDUP;
                default: begin
                    case ($urandom_range(0, 9))
                        6: kind = PH_MAX;
                        7: kind = PH_MIN;
                        8: kind = PH_WILD;
                        9: kind = PH_WINDUP;
                        default: kind = PH_TYPICAL;
                    endcase
                end
            endcase
            idle_on = (phase == 3) || ($urandom_range(0, 3) != 0);
            load_phase(kind);
            len = (kind == PH_WINDUP) ? 100 : $urandom_range(20, 80);
            for (n = 0; n < len && random_sent < RANDOM_ITEMS; n++) begin
                // Long receiver hold-off while samples keep coming, or now and then a full drain
                if ((phase == 3 && n == 5) || $urandom_range(0, 199) == 0)
                    hold_request = LONG_HOLD;
                else if ((phase == 4 && n == 10) || (phase != 3 && $urandom_range(0, 99) == 0))
                    wait_drained();
                send_item(pick_angle(kind, n),
                          (kind == PH_WINDUP) ? 1'b0 : 1'($urandom_range(0, 19) == 0),
                          1'b0, '0);
                random_sent++;
            end
            wait_drained();
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_drives.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stalls, plus long hold-offs counted here
    initial begin
        int rx_wait;
        rx_wait = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                rx_wait      = hold_request;
                hold_request = 0;
            end
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else if (!idle_on || $urandom_range(0, 99) < 75) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                rx_wait = pick_gap() - 1;
            end
        end
    end

    // Compare each result transfer with the oldest outstanding drive word
    always @(posedge aclk) begin : check_results
        drive_word_t head;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_drives.size() == 0) begin
                note_mismatch($sformatf("result %0d with nothing outstanding", results_seen));
            end else begin
                head = pending_drives.pop_front();
                if (m_tdata !== head.drive)
                    note_mismatch($sformatf("result %0d drive %0d, want %0d", results_seen,
                                            $signed(m_tdata), head.drive));
                if (m_tuser[0] !== head.clipped)
                    note_mismatch($sformatf("result %0d clipped %b, want %b", results_seen,
                                            m_tuser[0], head.clipped));
            end
            results_seen++;
        end
    end

    // Watchdog
    initial begin
        #RUN_LIMIT_NS;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
sv/pdc_pkg.sv
sv/pdc_divider.sv
sv/pid_deadband_controller.sv
test/tb_top.sv
